// ===== rtl/sm4_pkg.sv =====
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared widths, constants, codes and the round-constant generator used by
// the SM4 block encryption engine and its channel interfaces.
// ----------------------------------------------------------------------------
package sm4_pkg;

	// Round count and counter width
	localparam int ROUND_COUNT = 32;
	localparam int RND_W       = $clog2(ROUND_COUNT);

	// Channel payload widths
	localparam int HALF_W    = 64;
	localparam int WORD_W    = 32;
	localparam int CFG_IDX_W = 1;

	// System parameters FK
	localparam logic [WORD_W-1:0] FK0 = 32'hA3B1BAC6;
	localparam logic [WORD_W-1:0] FK1 = 32'h56AA3350;
	localparam logic [WORD_W-1:0] FK2 = 32'h677D9197;
	localparam logic [WORD_W-1:0] FK3 = 32'hB27022DC;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} cfg_reg_t;

	// Linear map selection of the shared round unit
	typedef enum logic {
		RM_DATA = 1'b0,
		RM_KEY  = 1'b1
	} round_mode_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_KEXP = 3'b010,
		ST_ENC  = 3'b100
	} state_t;

	// Working words of one round: index 0 is the oldest word
	typedef logic [3:0][WORD_W-1:0] words_t;

	// CK word for round i: byte j (j = 0 most significant) is (4*i + j) * 7 mod 256
	function automatic logic [WORD_W-1:0] ck_word(input logic [RND_W-1:0] i);
		logic [WORD_W-1:0] w;
		logic [7:0]        idx;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			idx = 8'({i, 2'(j)});
			w[WORD_W-1-8*j -: 8] = idx * 8'd7;
		end
		return w;
	endfunction

endpackage

// ===== rtl/sm4_if.sv =====
// ----------------------------------------------------------------------------
// sm4 channel interfaces
// Valid/ready channels for plaintext blocks, ciphertext blocks and
// configuration register writes.
// ----------------------------------------------------------------------------
interface sm4_plain_if;
	import sm4_pkg::*;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] block_high;
	logic [HALF_W-1:0] block_low;
	modport source (output valid, output block_high, output block_low, input ready);
	modport sink   (input valid, input block_high, input block_low, output ready);
endinterface

interface sm4_cipher_if;
	import sm4_pkg::*;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] cipher_high;
	logic [HALF_W-1:0] cipher_low;
	modport source (output valid, output cipher_high, output cipher_low, input ready);
	modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

interface sm4_cfg_if;
	import sm4_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [HALF_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sm4_round.sv =====
// ----------------------------------------------------------------------------
// sm4_round
// Shared SM4 round unit: nxt = w0 ^ T(w1 ^ w2 ^ w3 ^ k), where T is the
// byte-wise S-box followed by the data map L or the key map L'.
// ----------------------------------------------------------------------------
module sm4_round import sm4_pkg::*; (
	input  words_t            words,
	input  logic [WORD_W-1:0] rk,
	input  round_mode_t       mode,
	output logic [WORD_W-1:0] nxt
);

	localparam logic [7:0] SBOX [256] = '{
		8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
		8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
		8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
		8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
		8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
		8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
		8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
		8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
		8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
		8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
		8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
		8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
		8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
		8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
		8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
	};

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] sub;
	logic [WORD_W-1:0] lin;

	// Combine the three newer words with the round key or constant
	assign mix = words[1] ^ words[2] ^ words[3] ^ rk;

	// Substitute each byte
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			sub[8*b +: 8] = SBOX[mix[8*b +: 8]];
		end
	end

	// Apply the linear map of the selected schedule
	always_comb begin
		unique case (mode)
			RM_KEY:  lin = sub ^ rotl(sub, 13) ^ rotl(sub, 23);
			RM_DATA: lin = sub ^ rotl(sub, 2) ^ rotl(sub, 10) ^ rotl(sub, 18) ^ rotl(sub, 24);
			default: lin = sub;
		endcase
	end

	assign nxt = words[0] ^ lin;

endmodule

// ===== rtl/sm4_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// sm4_block_encrypt
// SM4 encryption of one 128-bit block per transfer, one round per cycle on a
// shared round unit, with cached round keys expanded on the same unit.
// ----------------------------------------------------------------------------
//
//   channel  role    payload                        transfer when
//   plain    sink    block_high, block_low          plain.valid & plain.ready
//   cipher   source  cipher_high, cipher_low        cipher.valid & cipher.ready
//   cfg      sink    index (0 key_high, 1 key_low)  cfg.valid & cfg.ready
//
// A block occupies the engine for the accept cycle plus 32 rounds; the result
// register loads on the last round. After a key write, the first block waits
// while the single round unit first computes the 32 round keys.
// Reset clears the key registers and marks the round keys stale.
// plain and cfg are ready only while the sequencer is idle; the last round
// holds while a previous result still sits unread in the output register.
//
module sm4_block_encrypt import sm4_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	sm4_plain_if.sink    plain,
	sm4_cipher_if.source cipher,
	sm4_cfg_if.sink      cfg
);

	localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

	state_t            state_q;
	logic [RND_W-1:0]  rnd_q;
	logic              keys_valid_q;
	logic              out_valid_q;
	logic [HALF_W-1:0] key_high_q;
	logic [HALF_W-1:0] key_low_q;
	logic [HALF_W-1:0] blk_high_q;
	logic [HALF_W-1:0] blk_low_q;
	logic [HALF_W-1:0] ct_high_q;
	logic [HALF_W-1:0] ct_low_q;
	words_t            w_q;
	logic [WORD_W-1:0] rk_q;
	logic [WORD_W-1:0] rk_mem [ROUND_COUNT];

	logic              acc;
	logic              cfg_wr;
	logic              last_rnd;
	logic              kexp_step;
	logic              enc_step;
	logic              enc_done;
	logic [RND_W-1:0]  rnd_nxt;
	round_mode_t       mode;
	logic [WORD_W-1:0] rk;
	logic [WORD_W-1:0] nxt;
	words_t            blk_words;
	words_t            key_words;

	// Handshakes
	assign plain.ready  = (state_q == ST_IDLE);
	assign cfg.ready    = (state_q == ST_IDLE);
	assign cipher.valid = out_valid_q;
	assign cipher.cipher_high = ct_high_q;
	assign cipher.cipher_low  = ct_low_q;

	assign acc       = plain.valid && plain.ready;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign last_rnd  = (rnd_q == RND_LAST);
	assign kexp_step = (state_q == ST_KEXP);
	assign enc_step  = (state_q == ST_ENC) && !last_rnd;
	assign enc_done  = (state_q == ST_ENC) && last_rnd && (!out_valid_q || cipher.ready);

	// Next round index: restart on accept, advance while rounds run
	always_comb begin
		rnd_nxt = rnd_q;
		if (acc) begin
			rnd_nxt = '0;
		end else if (kexp_step || enc_step) begin
			rnd_nxt = rnd_q + 1'b1;
		end
	end

	// Select schedule and round key for the shared unit
	assign mode = (state_q == ST_KEXP) ? RM_KEY : RM_DATA;
	assign rk   = (state_q == ST_KEXP) ? ck_word(rnd_q) : rk_q;

	sm4_round u_round (
		.words (w_q),
		.rk    (rk),
		.mode  (mode),
		.nxt   (nxt)
	);

	// Word order: index 0 holds X0 (or K0)
	assign blk_words = {plain.block_low[31:0], plain.block_low[63:32],
		plain.block_high[31:0], plain.block_high[63:32]};
	assign key_words = {key_low_q[31:0] ^ FK3, key_low_q[63:32] ^ FK2,
		key_high_q[31:0] ^ FK1, key_high_q[63:32] ^ FK0};

	// Sequencer, key registers and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rnd_q        <= '0;
			keys_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			key_high_q   <= '0;
			key_low_q    <= '0;
		end else begin
			rnd_q <= rnd_nxt;
			// Take configuration writes
			if (cfg_wr) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_KEY_HIGH: key_high_q <= cfg.data;
					REG_KEY_LOW:  key_low_q  <= cfg.data;
					default: ;
				endcase
				keys_valid_q <= 1'b0;
			end
			// Raise the result on the last round, drop it once transferred
			if (enc_done) begin
				out_valid_q <= 1'b1;
			end else if (cipher.valid && cipher.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= keys_valid_q ? ST_ENC : ST_KEXP;
					end
				end
				ST_KEXP: begin
					if (last_rnd) begin
						keys_valid_q <= 1'b1;
						state_q      <= ST_ENC;
					end
				end
				ST_ENC: begin
					if (enc_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working words, held block and result
	always_ff @(posedge clk) begin
		if (acc) begin
			blk_high_q <= plain.block_high;
			blk_low_q  <= plain.block_low;
			w_q        <= keys_valid_q ? blk_words : key_words;
		end else if (kexp_step && last_rnd) begin
			w_q <= {blk_low_q[31:0], blk_low_q[63:32], blk_high_q[31:0], blk_high_q[63:32]};
		end else if (kexp_step || enc_step) begin
			w_q <= {nxt, w_q[3], w_q[2], w_q[1]};
		end
		if (enc_done) begin
			ct_high_q <= {nxt, w_q[3]};
			ct_low_q  <= {w_q[2], w_q[1]};
		end
	end

	// Round key cache: fill during expansion, fetch the key of the next round
	always_ff @(posedge clk) begin
		if (kexp_step) begin
			rk_mem[rnd_q] <= nxt;
		end
		rk_q <= rk_mem[rnd_nxt];
	end

`ifndef SYNTHESIS
	a_kexp_on_stale: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !keys_valid_q) |=> (state_q == ST_KEXP))
		else $error("stale round keys did not start expansion");

	a_enc_keys_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENC) |-> keys_valid_q)
		else $error("encryption running on stale round keys");

	a_kexp_to_enc: assert property (@(posedge clk) disable iff (!arst_n)
		(kexp_step && last_rnd) |=> (keys_valid_q && state_q == ST_ENC && rnd_q == '0))
		else $error("key expansion did not hand over to encryption");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ENC && last_rnd))
		else $error("result raised outside the last round");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !cipher.ready) |=> out_valid_q && $stable(ct_high_q))
		else $error("unread result overwritten");
`endif

endmodule
